### rtl/core/sidt_pkg.sv
`default_nettype none

package sidt_pkg;

   // Table geometry; the ID field is four bits wide, so at most sixteen IDs
   localparam int MAX_IDS  = 16;
   localparam int ID_W     = 4;
   localparam int CNT_W    = 5;
   localparam int IP_W     = 32;
   localparam int PORT_W   = 16;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_CONNECT = 2'd0,
      CMD_CHECK   = 2'd1,
      CMD_RELEASE = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED    = 3'd0,
      ST_FULL       = 3'd1,
      ST_CHECK_OK   = 3'd2,
      ST_CHECK_FAIL = 3'd3,
      ST_RELEASED   = 3'd4,
      ST_NOT_FOUND  = 3'd5
   } status_type;

   // Match result handed from one table cell to the next
   typedef struct packed {
      logic            hit;
      logic [ID_W-1:0] id;
   } match_type;

   typedef struct packed {
      logic bind_en;
      logic clear;
   } slot_ctl_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

`default_nettype wire

### rtl/core/sidt_if.sv
`default_nettype none

interface sidt_req_if;
   import sidt_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [IP_W-1:0]   peer_ip;
   logic [PORT_W-1:0] peer_port;
   logic [ID_W-1:0]   claimed_id;

   modport source (output valid, command, peer_ip, peer_port, claimed_id, input ready);
   modport sink   (input valid, command, peer_ip, peer_port, claimed_id, output ready);
endinterface

interface sidt_rsp_if;
   import sidt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     network_id;

   modport source (output valid, status, network_id, input ready);
   modport sink   (input valid, status, network_id, output ready);
endinterface

`default_nettype wire

### rtl/core/sidt_slot_cell.sv
`default_nettype none

module sidt_slot_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sidt_pkg::slot_ctl_type      ctl,
   input  wire logic [sidt_pkg::IP_W-1:0]   peer_ip,
   input  wire logic [sidt_pkg::PORT_W-1:0] peer_port,
   input  wire logic [sidt_pkg::ID_W-1:0]   cell_id,
   input  wire sidt_pkg::match_type         chain_in,
   output sidt_pkg::match_type              chain_out
);
   import sidt_pkg::*;

   logic              valid_ff, valid_in;
   logic [IP_W-1:0]   ip_ff;
   logic [PORT_W-1:0] port_ff;
   logic              match;

   assign match = valid_ff && (ip_ff == peer_ip) && (port_ff == peer_port);

   // Bindings are unique, so at most one cell matches: merge by OR
   assign chain_out.hit = chain_in.hit | match;
   assign chain_out.id  = chain_in.id | (match ? cell_id : '0);

   always_comb begin
      valid_in = valid_ff;
      if (ctl.bind_en) begin
         valid_in = 1'b1;
      end else if (ctl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.bind_en) begin
         ip_ff   <= peer_ip;
         port_ff <= peer_port;
      end
   end

endmodule

`default_nettype wire

### rtl/core/sidt_stack_cell.sv
`default_nettype none

module sidt_stack_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sidt_pkg::stack_ctl_type   ctl,
   input  wire logic [sidt_pkg::ID_W-1:0] reset_id,
   input  wire logic [sidt_pkg::ID_W-1:0] from_above,
   input  wire logic [sidt_pkg::ID_W-1:0] from_below,
   output logic [sidt_pkg::ID_W-1:0]      id_out
);
   import sidt_pkg::*;

   logic [ID_W-1:0] id_ff, id_in;

   // Push shifts toward the bottom, pop shifts toward the top
   always_comb begin
      id_in = id_ff;
      if (ctl.push) begin
         id_in = from_above;
      end else if (ctl.pop) begin
         id_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= reset_id;
      end else begin
         id_ff <= id_in;
      end
   end

   assign id_out = id_ff;

endmodule

`default_nettype wire

### rtl/core/session_id_table_core.sv
`default_nettype none

// Channel   Dir  Beat fields                                      Handshake
// req_bus   in   command, peer_ip, peer_port, claimed_id          valid / ready
// rsp_bus   out  status, network_id                               valid / ready
//
// One request per cycle: the lookup over all table cells, the decision and
// the table and stack update happen in the cycle the request beat is taken;
// the answer is registered at that edge and shows on rsp_bus the next cycle.
// Reset clears every valid mark, reloads the free stack with all IDs (the
// highest on top) and empties the response register.
// A stalled response blocks new requests; taking it frees the slot at once.

module session_id_table_core (
   input wire logic  clock,
   input wire logic  reset,
   sidt_req_if.sink  req_bus,
   sidt_rsp_if.source rsp_bus
);
   import sidt_pkg::*;

   // Lookup chain through the table cells; entry 0 feeds the first cell
   match_type       chain [MAX_IDS+1];
   logic [ID_W-1:0] stack_id [MAX_IDS];

   logic              accept;
   logic              hit;
   logic [ID_W-1:0]   hit_id;
   logic [ID_W-1:0]   top_id;
   logic              do_pop, do_push;
   stack_ctl_type     stack_ctl;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [ID_W-1:0]   net_id_ff, net_id_in;

   // Take a request whenever the response register is empty or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign chain[0] = '0;
   assign hit      = chain[MAX_IDS].hit;
   assign hit_id   = chain[MAX_IDS].id;
   assign top_id   = stack_id[0];

   genvar i;
   generate
      for (i = 0; i < MAX_IDS; i++) begin : g_cell
         slot_ctl_type slot_ctl;

         // Bind the popped ID to the peer, clear the released one
         assign slot_ctl.bind_en = do_pop && (top_id == ID_W'(i));
         assign slot_ctl.clear   = do_push && (hit_id == ID_W'(i));

         sidt_slot_cell u_slot (
            .clock     (clock),
            .reset     (reset),
            .ctl       (slot_ctl),
            .peer_ip   (req_bus.peer_ip),
            .peer_port (req_bus.peer_port),
            .cell_id   (ID_W'(i)),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
         );

         // Free stack cell; cell 0 is the top of stack
         sidt_stack_cell u_stack (
            .clock      (clock),
            .reset      (reset),
            .ctl        (stack_ctl),
            .reset_id   (ID_W'(MAX_IDS - 1 - i)),
            .from_above ((i == 0) ? hit_id : stack_id[(i == 0) ? 0 : i-1]),
            .from_below ((i == MAX_IDS-1) ? '0 : stack_id[(i == MAX_IDS-1) ? i : i+1]),
            .id_out     (stack_id[i])
         );
      end
   endgenerate

   // Decide the answer and the state change for the request beat
   always_comb begin
      do_pop    = 1'b0;
      do_push   = 1'b0;
      status_in = status_ff;
      net_id_in = net_id_ff;
      if (accept) begin
         net_id_in = '0;
         case (command_type'(req_bus.command))
            CMD_CONNECT: begin
               if (hit) begin
                  status_in = ST_GRANTED;
                  net_id_in = hit_id;
               end else if (free_count_ff == '0) begin
                  status_in = ST_FULL;
               end else begin
                  do_pop    = 1'b1;
                  status_in = ST_GRANTED;
                  net_id_in = top_id;
               end
            end
            CMD_CHECK: begin
               status_in = (hit && hit_id == req_bus.claimed_id) ? ST_CHECK_OK
                                                                 : ST_CHECK_FAIL;
            end
            CMD_RELEASE: begin
               if (hit) begin
                  do_push   = 1'b1;
                  status_in = ST_RELEASED;
                  net_id_in = hit_id;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               status_in = ST_CHECK_FAIL;
            end
         endcase
      end
   end

   // Drop a push onto a full stack; the binding is still cleared
   assign stack_ctl.push = do_push && (free_count_ff < CNT_W'(MAX_IDS));
   assign stack_ctl.pop  = do_pop;

   always_comb begin
      free_count_in = free_count_ff;
      if (stack_ctl.pop) begin
         free_count_in = free_count_ff - CNT_W'(1);
      end else if (stack_ctl.push) begin
         free_count_in = free_count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= CNT_W'(MAX_IDS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold the response payload unless a new beat is taken
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      net_id_ff <= net_id_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.network_id = net_id_ff;

endmodule

`default_nettype wire

### sim/session_id_table_tb_pkg.sv
`timescale 1ns / 100ps

package session_id_table_tb_pkg;
   import sidt_pkg::*;

   // The command field is two bits wide; this value has no operation behind it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      status_type      status;
      logic [ID_W-1:0] network_id;
   } session_answer_type;

   // Keeps its own copy of the session table and the free-ID stack and
   // queues the answer each accepted request must produce.
   class session_ledger;
      bit                 bound      [MAX_IDS];
      logic [IP_W-1:0]    bound_ip   [MAX_IDS];
      logic [PORT_W-1:0]  bound_port [MAX_IDS];
      logic [ID_W-1:0]    free_ids   [MAX_IDS];
      int                 free_count;
      session_answer_type answer_q[$];
      int                 error_count;

      function new();
         for (int i = 0; i < MAX_IDS; i++) begin
            bound[i]      = 1'b0;
            bound_ip[i]   = '0;
            bound_port[i] = '0;
            free_ids[i]   = ID_W'(i);
         end
         free_count  = MAX_IDS;
         error_count = 0;
      endfunction

      // Return the ID bound to the peer, or -1 when the peer is unbound
      function int find_peer(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
         int id;
         id = -1;
         for (int i = 0; i < MAX_IDS; i++) begin
            if (id < 0 && bound[i] && bound_ip[i] == ip && bound_port[i] == port) begin
               id = i;
            end
         end
         return id;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
                                 logic [PORT_W-1:0] port, logic [ID_W-1:0] claimed);
         int                 found;
         int                 fresh;
         session_answer_type answer;
         found             = find_peer(ip, port);
         answer.status     = ST_CHECK_FAIL;
         answer.network_id = '0;
         case (cmd)
            CMD_CONNECT: begin
               if (found >= 0) begin
                  answer.status     = ST_GRANTED;
                  answer.network_id = ID_W'(found);
               end else if (free_count == 0) begin
                  answer.status = ST_FULL;
               end else begin
                  free_count        = free_count - 1;
                  fresh             = free_ids[free_count];
                  bound[fresh]      = 1'b1;
                  bound_ip[fresh]   = ip;
                  bound_port[fresh] = port;
                  answer.status     = ST_GRANTED;
                  answer.network_id = ID_W'(fresh);
               end
            end
            CMD_CHECK: begin
               if (found >= 0 && found == claimed) begin
                  answer.status = ST_CHECK_OK;
               end
            end
            CMD_RELEASE: begin
               if (found >= 0) begin
                  bound[found] = 1'b0;
                  if (free_count < MAX_IDS) begin
                     free_ids[free_count] = ID_W'(found);
                     free_count           = free_count + 1;
                  end
                  answer.status     = ST_RELEASED;
                  answer.network_id = ID_W'(found);
               end else begin
                  answer.status = ST_NOT_FOUND;
               end
            end
            default: ;
         endcase
         answer_q.push_back(answer);
      endfunction

      task report_mismatch(string what);
         error_count++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [ID_W-1:0] network_id);
         session_answer_type answer;
         if (answer_q.size() == 0) begin
            report_mismatch($sformatf("response status %0d id %0d with nothing outstanding",
                                      status, network_id));
         end else begin
            answer = answer_q.pop_front();
            if (status !== answer.status) begin
               report_mismatch($sformatf("status %0d, predicted %0d", status, answer.status));
            end
            if (network_id !== answer.network_id) begin
               report_mismatch($sformatf("network_id %0d, predicted %0d",
                                         network_id, answer.network_id));
            end
         end
      endtask

      function int pending();
         return answer_q.size();
      endfunction
   endclass

endpackage

### sim/session_id_table_core_tb.sv
`timescale 1ns / 100ps

module session_id_table_core_tb;
   import sidt_pkg::*;
   import session_id_table_tb_pkg::*;

   localparam int POOL_SIZE       = 24;    // peers reused so lookups hit
   localparam int ITEMS_PER_PHASE = 300;
   localparam int HOLD_CYCLES     = 150;   // long receiver hold-off
   localparam int SETTLE_CYCLES   = 10;    // response lands in the cycle after the beat
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no beat on either channel

   logic clock;
   logic reset;

   sidt_req_if req_bus();
   sidt_rsp_if rsp_bus();

   session_ledger ledger;

   int  req_idle_pct;
   int  rsp_idle_pct;
   bit  hold_request;
   int  quiet_cycles = 0;

   logic [IP_W-1:0]   pool_ip   [POOL_SIZE];
   logic [PORT_W-1:0] pool_port [POOL_SIZE];

   session_id_table_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Response sink: drive ready at the falling edge. A hold-off request from
   // the stimulus is served here, counted in this process, while the sender
   // keeps offering beats so the response register backs up into the input.
   initial begin : rsp_driver
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Check every response beat against the oldest predicted answer
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         ledger.check_response(rsp_bus.status, rsp_bus.network_id);
      end
   end

   // Stop the run when neither channel has moved a beat for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request beat, with random idle cycles ahead of it, and hold it
   // until taken. Valid stays high after the beat; at the following falling edge
   // a drop lowers it, and the next call lowers it or offers its own beat.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
                               logic [PORT_W-1:0] port, logic [ID_W-1:0] claimed);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.peer_ip    <= ip;
      req_bus.peer_port  <= port;
      req_bus.claimed_id <= claimed;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      ledger.note_request(cmd, ip, port, claimed);
   endtask

   // Drop valid and wait until every predicted answer has come back
   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Fill the table, hit the full case, then walk each command and corner
   task automatic run_directed();
      send_request(CMD_CONNECT, '0, '0, '0);           // lowest peer, gets the top ID
      send_request(CMD_CONNECT, '1, '1, '1);           // highest peer
      send_request(CMD_CONNECT, '0, '1, '0);           // same address, other port
      for (int i = 3; i < MAX_IDS; i++) begin
         send_request(CMD_CONNECT, 32'hC0A8_0000 | i, PORT_W'(1000 + i), '0);
      end
      send_request(CMD_CONNECT, 32'h0A00_0001, 16'd5000, '0);  // stack empty: rejected
      send_request(CMD_CONNECT, '0, '0, '0);           // known peer keeps its ID
      send_request(CMD_CHECK, '0, '0, ID_W'(MAX_IDS - 1));      // correct claim
      send_request(CMD_CHECK, '1, '1, '0);             // bound to a different ID
      send_request(CMD_CHECK, 32'h0A00_0001, 16'd5000, '1);     // unbound peer
      send_request(CMD_RELEASE, '0, '0, '0);           // frees the top ID
      send_request(CMD_RELEASE, '0, '0, '0);           // already gone
      send_request(CMD_UNUSED, '1, '1, '1);            // no operation, fails like a check
      send_request(CMD_CONNECT, 32'h0A00_0001, 16'd5000, '0);  // reuses the freed ID
   endtask

   // Mostly pool peers so connects, checks and releases land on live
   // bindings; the rest are fresh peers that only miss or take a new ID.
   task automatic send_random();
      int               pick;
      int               slot;
      int               bound_id;
      logic [CMD_W-1:0] cmd;
      logic [IP_W-1:0]  ip;
      logic [PORT_W-1:0] port;
      logic [ID_W-1:0]  claimed;
      pick = $urandom_range(99);
      if (pick < 40) begin
         cmd = CMD_CONNECT;
      end else if (pick < 70) begin
         cmd = CMD_CHECK;
      end else if (pick < 95) begin
         cmd = CMD_RELEASE;
      end else begin
         cmd = CMD_UNUSED;
      end
      if ($urandom_range(99) < 85) begin
         slot = $urandom_range(POOL_SIZE - 1);
         ip   = pool_ip[slot];
         port = pool_port[slot];
      end else begin
         ip   = $urandom;
         port = PORT_W'($urandom);
      end
      claimed  = ID_W'($urandom_range(MAX_IDS - 1));
      // Bias checks toward the right ID so the pass path is taken often
      bound_id = ledger.find_peer(ip, port);
      if (bound_id >= 0 && $urandom_range(99) < 60) begin
         claimed = ID_W'(bound_id);
      end
      send_request(cmd, ip, port, claimed);
   endtask

   initial begin
      ledger             = new();
      reset              = 1'b1;
      hold_request       = 1'b0;
      req_idle_pct       = 8;
      rsp_idle_pct       = 85;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_CONNECT;
      req_bus.peer_ip    = '0;
      req_bus.peer_port  = '0;
      req_bus.claimed_id = '0;

      // Pool: the extremes first, then pairs that share an address
      pool_ip[0]   = '0;
      pool_port[0] = '0;
      pool_ip[1]   = '1;
      pool_port[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         pool_ip[i]   = (i % 2 == 1) ? pool_ip[i - 1] : $urandom;
         pool_port[i] = PORT_W'($urandom);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      // Slow receiver, then slow sender, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 8;
               rsp_idle_pct = 85;
            end
            1: begin
               req_idle_pct = 85;
               rsp_idle_pct = 8;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               // Pause the sender until all answers are in, then stall
               // the receiver while beats keep coming
               drain_responses();
               hold_request = 1'b1;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_random();
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (ledger.error_count == 0 && ledger.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
